// ----- rtl/spndf_pkg.sv -----
package spndf_pkg;

   localparam int WINDOW      = 64;
   localparam int MAX_ITEMS   = 65536;
   localparam int COORD_WIDTH = 32;

   // coordinates are taken from the low CW bits of the 32-bit fields
   localparam int CW      = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
   localparam int DIFF_W  = CW + 2;
   localparam int PTR_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int FILL_W  = $clog2(WINDOW + 1);
   localparam int CNT_W   = $clog2(MAX_ITEMS + 1);
   localparam int THR_W   = 31;
   localparam int IDX_W   = 16;
   localparam int TOT_W   = 17;
   localparam logic [THR_W-1:0] THR_RESET = 31'd655;

   typedef struct packed {
      logic               first_of_set;
      logic               is_fat;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
   } req_type;

   typedef struct packed {
      logic             is_unique;
      logic [IDX_W-1:0] new_index;
      logic [TOT_W-1:0] fat_total;
      logic [TOT_W-1:0] thin_total;
      logic             window_exhausted;
   } rsp_type;

endpackage

// ----- rtl/spndf_front.sv -----
module spndf_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  spndf_pkg::req_type req_data,
   output logic              item_valid,
   output spndf_pkg::req_type item_data,
   input  logic              item_take
);
   import spndf_pkg::*;

   req_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push_ok, take_ok;

   assign full       = (cnt_ff == 2'd2);
   assign item_valid = (cnt_ff != 2'd0);
   assign item_data  = entry_ff[rd_ptr_ff];
   assign push_ok    = push && !full;
   assign take_ok    = item_take && item_valid;

   always_comb begin
      wr_ptr_in = push_ok ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = take_ok ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push_ok} - {1'b0, take_ok};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         entry_ff[wr_ptr_ff] <= req_data;
      end
   end

endmodule

// ----- rtl/spndf_back.sv -----
module spndf_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [spndf_pkg::THR_W-1:0]  threshold,
   input  logic                         item_valid,
   input  spndf_pkg::req_type           item_data,
   output logic                         item_take,
   output logic                         empty,
   input  logic                         pop,
   output spndf_pkg::rsp_type           rsp_data
);
   import spndf_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [2*CW-1:0]  mem [WINDOW];

   logic [1:0]        state_ff, state_in;
   req_type           item_ff, item_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [PTR_W-1:0]  ring_ff, ring_in;
   logic [CNT_W-1:0]  fat_ff, fat_in;
   logic [CNT_W-1:0]  thin_ff, thin_in;
   logic [PTR_W-1:0]  pos_ff, pos_in;
   logic [FILL_W-1:0] scanned_ff, scanned_in;
   logic              dup_ff, dup_in;
   logic              stop_ff, stop_in;
   logic [2*CW-1:0]   rd_data_ff;
   logic              out_valid_ff, out_valid_in;
   rsp_type           out_ff, out_in;

   logic [PTR_W-1:0]        rd_addr;
   logic                    mem_we;
   logic [FILL_W-1:0]       fill_eff;
   logic [PTR_W-1:0]        ring_eff;
   logic signed [DIFF_W-1:0] new_x, new_y, old_x, old_y, dx, dy, adx, thr_s;
   logic                    stop_hit, dup_hit;
   logic [FILL_W-1:0]       scanned_nx;
   logic                    slot_free, is_new;
   logic [CNT_W:0]          sum;

   function automatic logic [PTR_W-1:0] prev_pos(input logic [PTR_W-1:0] p);
      prev_pos = (p == '0) ? PTR_W'(WINDOW - 1) : p - 1'b1;
   endfunction

   assign empty    = !out_valid_ff;
   assign rsp_data = out_ff;

   always_comb begin
      new_x = DIFF_W'(signed'(item_ff.pos_x[CW-1:0]));
      new_y = DIFF_W'(signed'(item_ff.pos_y[CW-1:0]));
      old_x = DIFF_W'(signed'(rd_data_ff[2*CW-1:CW]));
      old_y = DIFF_W'(signed'(rd_data_ff[CW-1:0]));
      thr_s = signed'(DIFF_W'(threshold));
      dy    = new_y - old_y;
      dx    = new_x - old_x;
      adx   = dx[DIFF_W-1] ? -dx : dx;
      stop_hit = dy > thr_s;
      dup_hit  = !stop_hit && (adx <= thr_s);
   end

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      fill_in      = fill_ff;
      ring_in      = ring_ff;
      fat_in       = fat_ff;
      thin_in      = thin_ff;
      pos_in       = pos_ff;
      scanned_in   = scanned_ff;
      dup_in       = dup_ff;
      stop_in      = stop_ff;
      out_valid_in = out_valid_ff && !pop;
      out_in       = out_ff;
      item_take    = 1'b0;
      mem_we       = 1'b0;
      rd_addr      = prev_pos(pos_ff);
      fill_eff     = item_data.first_of_set ? '0 : fill_ff;
      ring_eff     = item_data.first_of_set ? '0 : ring_ff;
      scanned_nx   = scanned_ff + 1'b1;
      slot_free    = !out_valid_ff || pop;
      is_new       = !dup_ff;
      sum          = {1'b0, fat_ff} + {1'b0, thin_ff};

      case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               item_take  = 1'b1;
               item_in    = item_data;
               scanned_in = '0;
               dup_in     = 1'b0;
               stop_in    = 1'b0;
               if (item_data.first_of_set) begin
                  fill_in = '0;
                  ring_in = '0;
                  fat_in  = '0;
                  thin_in = '0;
               end
               rd_addr = prev_pos(ring_eff);
               pos_in  = rd_addr;
               state_in = (fill_eff == '0) ? ST_DONE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            // rd_data_ff holds the entry at pos_ff
            scanned_in = scanned_nx;
            if (stop_hit || dup_hit || scanned_nx == fill_ff) begin
               dup_in   = dup_hit;
               stop_in  = stop_hit;
               state_in = ST_DONE;
            end else begin
               pos_in = prev_pos(pos_ff);
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_in.is_unique = is_new;
               out_in.new_index = '0;
               if (is_new) begin
                  mem_we  = 1'b1;
                  ring_in = (ring_ff == PTR_W'(WINDOW - 1)) ? '0 : ring_ff + 1'b1;
                  if (fill_ff != FILL_W'(WINDOW)) begin
                     fill_in = fill_ff + 1'b1;
                  end
                  if (item_ff.is_fat) begin
                     if (fat_ff != CNT_W'(MAX_ITEMS)) begin
                        fat_in = fat_ff + 1'b1;
                     end
                  end else begin
                     if (thin_ff != CNT_W'(MAX_ITEMS)) begin
                        thin_in = thin_ff + 1'b1;
                     end
                  end
                  out_in.new_index = (sum > (CNT_W + 1)'(65535)) ? '1 : IDX_W'(sum);
               end
               out_in.fat_total        = TOT_W'(fat_in);
               out_in.thin_total       = TOT_W'(thin_in);
               out_in.window_exhausted = is_new && !stop_ff &&
                                         (scanned_ff == FILL_W'(WINDOW));
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         ring_ff      <= '0;
         fat_ff       <= '0;
         thin_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         ring_ff      <= ring_in;
         fat_ff       <= fat_in;
         thin_ff      <= thin_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff    <= item_in;
      pos_ff     <= pos_in;
      scanned_ff <= scanned_in;
      dup_ff     <= dup_in;
      stop_ff    <= stop_in;
      out_ff     <= out_in;
   end

   // kept-point store: x in the upper half, y in the lower
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[ring_ff] <= {item_ff.pos_x[CW-1:0], item_ff.pos_y[CW-1:0]};
      end
      rd_data_ff <= mem[rd_addr];
   end

endmodule

// ----- rtl/sorted_point_near_duplicate_filter.sv -----
// Near-duplicate filter for y-then-x sorted Q16.16 points. Words written with
// push are held in a two-word input queue; a scan engine then compares each
// point with the kept points of the current set, newest first, one kept point
// per clock through the single read port of the kept-point memory. The engine
// finishes each word before it takes the next; it scans from 0 up to WINDOW
// (64) kept points per word. Results wait in a one-word output register read
// with empty/pop; while it is occupied the engine holds its finished word and
// the input queue keeps filling.
// csr_wdata sets the match threshold (reset 655, about 0.01).
module sorted_point_near_duplicate_filter (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   output logic                        full,
   input  spndf_pkg::req_type          req_data,
   output logic                        empty,
   input  logic                        pop,
   output spndf_pkg::rsp_type          rsp_data,
   input  logic                        csr_we,
   input  logic [spndf_pkg::THR_W-1:0] csr_wdata
);
   import spndf_pkg::*;

   logic [THR_W-1:0] thr_ff, thr_in;
   logic             item_valid;
   req_type          item_data;
   logic             item_take;

   assign thr_in = csr_we ? csr_wdata : thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else begin
         thr_ff <= thr_in;
      end
   end

   spndf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .req_data   (req_data),
      .item_valid (item_valid),
      .item_data  (item_data),
      .item_take  (item_take)
   );

   spndf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .threshold  (thr_ff),
      .item_valid (item_valid),
      .item_data  (item_data),
      .item_take  (item_take),
      .empty      (empty),
      .pop        (pop),
      .rsp_data   (rsp_data)
   );

endmodule
